@@ rtl/core/sed_pkg.sv @@
package sed_pkg;

    // result slots set aside per input byte, one of each kind: escape value, plain byte, end flush
    localparam int SED_MAX_RES     = 3;
    localparam int SED_QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_BACKSLASH = 2'd1,
        MODE_HEX       = 2'd2,
        MODE_OCTAL     = 2'd3
    } t_mode;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_LA        = 8'h61;
    localparam logic [7:0] CH_LF        = 8'h66;
    localparam logic [7:0] CH_UA        = 8'h41;
    localparam logic [7:0] CH_UF        = 8'h46;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_A         = 8'h61;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_E         = 8'h65;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_T         = 8'h74;

    localparam logic [7:0] CODE_CR  = 8'd13;
    localparam logic [7:0] CODE_BEL = 8'd7;
    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_ESC = 8'd27;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_TAB = 8'd9;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0]                    num;
        t_result [SED_MAX_RES-1:0]     res;
    } t_result_set;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic logic [7:0] map_escape(input logic [7:0] b);
        case (b)
            CH_R:    return CODE_CR;
            CH_A:    return CODE_BEL;
            CH_B:    return CODE_BS;
            CH_E:    return CODE_ESC;
            CH_N:    return CODE_LF;
            CH_T:    return CODE_TAB;
            default: return b;
        endcase
    endfunction

    function automatic logic is_dec(input logic [7:0] b);
        return (b >= CH_0) && (b <= CH_9);
    endfunction

    // low nibble of '0'..'9' is the digit; 'a'..'f' and 'A'..'F' have 1..6 there
    function automatic t_hex hex_digit(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b0;
        h.val = b[3:0];
        if (is_dec(b)) begin
            h.ok = 1'b1;
        end else if (((b >= CH_LA) && (b <= CH_LF)) || ((b >= CH_UA) && (b <= CH_UF))) begin
            h.ok  = 1'b1;
            h.val = b[3:0] + 4'd9;
        end
        return h;
    endfunction

    function automatic t_result mk_result(input logic [7:0] data, input logic has);
        t_result r;
        r.data = data;
        r.has  = has;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

@@ rtl/core/sed_if.sv @@
interface sed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface sed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_has_byte, input out_last,
                    output ready);
endinterface

@@ rtl/core/string_escape_decoder.sv @@
// Decodes the body of a C-style string literal, one raw byte per input transfer with a
// last flag, into decoded bytes (backslash escapes: \x hex, decimal-digit octal, named
// control codes; a zero byte stops decoding for the rest of the literal). Each literal
// ends in exactly one result with out_last set, a bare marker with out_has_byte low if
// the final byte gives nothing else. Input bytes are taken one per cycle while each gives
// at most one result and the output is ready. The result queue drains one transfer per
// cycle while the output is ready, so every extra result of a byte holds the input back
// once the queue slack is used up; the default depth of 4 absorbs one extra result, depth
// 3 none. A byte goes through the input register, then decode into the result queue.
// QUEUE_DEPTH (3 or more) sets the result queue size.
module string_escape_decoder #(
    parameter int QUEUE_DEPTH = sed_pkg::SED_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sed_in_if.sink    i_in,
    sed_out_if.source o_out
);
    import sed_pkg::*;

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        w_room;
    logic        w_fire;
    t_result_set w_set;

    assign w_fire     = r_in_vld && w_room;
    assign i_in.ready = !r_in_vld || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.in_last;
        end
    end

    sed_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (w_set)
    );

    sed_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire),
        .i_set   (w_set),
        .o_room  (w_room),
        .o_out   (o_out)
    );

endmodule

@@ rtl/core/sed_decode.sv @@
module sed_decode (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output sed_pkg::t_result_set o_res
);
    import sed_pkg::*;

    t_mode      r_mode, n_mode, pr_mode;
    logic [1:0] r_cnt, n_cnt, pr_cnt;
    logic [7:0] r_val, n_val, pr_val;
    logic       r_stop, n_stop, pr_stop;

    logic       w_esc;
    logic [7:0] w_esc_val;
    logic       w_plain;
    t_hex       w_hex;
    logic [7:0] w_acc_hex;
    logic [7:0] w_acc_oct;
    logic [1:0] w_cnt_inc;

    assign w_hex     = hex_digit(i_byte);
    assign w_acc_hex = {r_val[3:0], w_hex.val};
    assign w_acc_oct = {r_val[4:0], 3'b000} + {4'b0000, i_byte[3:0]};
    assign w_cnt_inc = r_cnt + 2'd1;

    // next state: state after this byte, before the end-of-literal reset
    always_comb begin
        pr_mode   = r_mode;
        pr_cnt    = r_cnt;
        pr_val    = r_val;
        pr_stop   = r_stop;
        w_esc     = 1'b0;
        w_esc_val = r_val;
        w_plain   = 1'b0;
        if (!r_stop) begin
            case (r_mode)
                MODE_BACKSLASH: begin
                    if (i_byte == CH_X) begin
                        pr_mode = MODE_HEX;
                        pr_cnt  = 2'd0;
                        pr_val  = 8'd0;
                    end else if (is_dec(i_byte)) begin
                        pr_mode = MODE_OCTAL;
                        pr_cnt  = 2'd1;
                        pr_val  = {4'b0000, i_byte[3:0]};
                    end else begin
                        w_esc     = 1'b1;
                        w_esc_val = map_escape(i_byte);
                        pr_mode   = MODE_NORMAL;
                    end
                end
                MODE_HEX: begin
                    if (w_hex.ok) begin
                        pr_val = w_acc_hex;
                        if (w_cnt_inc >= 2'd2) begin
                            w_esc     = 1'b1;
                            w_esc_val = w_acc_hex;
                            pr_mode   = MODE_NORMAL;
                            pr_cnt    = 2'd0;
                        end else begin
                            pr_cnt = w_cnt_inc;
                        end
                    end else begin
                        w_esc   = 1'b1;
                        pr_mode = MODE_NORMAL;
                        pr_cnt  = 2'd0;
                        w_plain = 1'b1;
                    end
                end
                MODE_OCTAL: begin
                    if (is_dec(i_byte)) begin
                        pr_val = w_acc_oct;
                        if (w_cnt_inc == 2'd3) begin
                            w_esc     = 1'b1;
                            w_esc_val = w_acc_oct;
                            pr_mode   = MODE_NORMAL;
                            pr_cnt    = 2'd0;
                        end else begin
                            pr_cnt = w_cnt_inc;
                        end
                    end else begin
                        w_esc   = 1'b1;
                        pr_mode = MODE_NORMAL;
                        pr_cnt  = 2'd0;
                        w_plain = 1'b1;
                    end
                end
                default: begin
                    w_plain = 1'b1;
                end
            endcase
            if (w_plain) begin
                if (i_byte == CH_NUL) begin
                    pr_stop = 1'b1;
                end else if (i_byte == CH_BACKSLASH) begin
                    pr_mode = MODE_BACKSLASH;
                end
            end
        end
    end

    always_comb begin
        if (i_last) begin
            n_mode = MODE_NORMAL;
            n_cnt  = 2'd0;
            n_val  = 8'd0;
            n_stop = 1'b0;
        end else begin
            n_mode = pr_mode;
            n_cnt  = pr_cnt;
            n_val  = pr_val;
            n_stop = pr_stop;
        end
    end

    // outputs: escape value first, then the plain byte, then the end flush or bare end marker
    always_comb begin
        logic [1:0] k;
        logic [1:0] kl;
        k     = 2'd0;
        kl    = 2'd0;
        o_res = '0;
        if (w_esc) begin
            o_res.res[k] = mk_result(w_esc_val, 1'b1);
            k            = k + 2'd1;
        end
        if (w_plain && (i_byte != CH_NUL) && (i_byte != CH_BACKSLASH)) begin
            o_res.res[k] = mk_result(i_byte, 1'b1);
            k            = k + 2'd1;
        end
        if (i_last) begin
            if (!pr_stop) begin
                if (pr_mode == MODE_BACKSLASH) begin
                    o_res.res[k] = mk_result(8'd0, 1'b1);
                    k            = k + 2'd1;
                end else if ((pr_mode == MODE_HEX) || (pr_mode == MODE_OCTAL)) begin
                    o_res.res[k] = mk_result(pr_val, 1'b1);
                    k            = k + 2'd1;
                end
            end
            if (k == 2'd0) begin
                o_res.res[k] = mk_result(8'd0, 1'b0);
                k            = k + 2'd1;
            end
            kl                     = k - 2'd1;
            o_res.res[kl].last     = 1'b1;
        end
        o_res.num = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_cnt  <= 2'd0;
            r_val  <= 8'd0;
            r_stop <= 1'b0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_cnt  <= n_cnt;
            r_val  <= n_val;
            r_stop <= n_stop;
        end
    end

endmodule

@@ rtl/core/sed_outq.sv @@
module sed_outq #(
    parameter int DEPTH = sed_pkg::SED_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  sed_pkg::t_result_set i_set,
    output logic                 o_room,
    sed_out_if.source            o_out
);
    import sed_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_result       r_q [DEPTH];
    t_result       n_q [DEPTH];
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] w_base;
    logic          w_pop;

    assign w_pop  = (r_cnt != '0) && o_out.ready;
    // room for a full result set, counting the slot freed by this cycle's transfer
    assign o_room = ({1'b0, r_cnt} + (CW+1)'(SED_MAX_RES))
                    <= ((CW+1)'(DEPTH) + {{CW{1'b0}}, w_pop});
    assign w_base = r_cnt - {{(CW-1){1'b0}}, w_pop};

    always_comb begin
        n_q = r_q;
        if (w_pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_q[i] = r_q[i+1];
            end
        end
        if (i_push) begin
            for (int i = 0; i < DEPTH; i++) begin
                for (int k = 0; k < SED_MAX_RES; k++) begin
                    if ((k < int'(i_set.num))
                        && (({1'b0, w_base} + (CW+1)'(k)) == (CW+1)'(i))) begin
                        n_q[i] = i_set.res[k];
                    end
                end
            end
        end
    end

    always_comb begin
        n_cnt = w_base;
        if (i_push) begin
            n_cnt = w_base + CW'(i_set.num);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_out.valid        = (r_cnt != '0);
    assign o_out.out_byte     = r_q[0].data;
    assign o_out.out_has_byte = r_q[0].has;
    assign o_out.out_last     = r_q[0].last;

endmodule

@@ rtl/core/sed_checker.sv @@
module sed_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_has_byte,
    input logic       i_out_last
);

    // a result waiting for transfer holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable({i_out_byte, i_out_has_byte, i_out_last}))
        else $error("stalled result changed");

    // a bare end marker only closes a literal and carries a zero byte
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_has_byte |-> i_out_last && (i_out_byte == 8'h00))
        else $error("bare marker without last or with data");

    // input only backs up while results are pending
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result pending");

    a_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("not empty after reset");

    a_in_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) && !i_in_valid |-> !i_out_valid)
        else $error("result without any input transfer");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_byte     (o_out.out_byte),
    .i_out_has_byte (o_out.out_has_byte),
    .i_out_last     (o_out.out_last)
);
